FILE: sv/sctag_pkg.sv
// sctag_pkg: shared constants, access codes and handshake structs for the
// sector cache tag engine; no dependencies
`default_nettype none

package sctag_pkg;

    localparam int SLOTS_DEF     = 256;
    localparam int ADDR_BITS_DEF = 48;
    localparam int LBA_W         = 48;
    localparam int SLOT_W        = 8;
    localparam int KEY_EXT_W     = 64;

    typedef enum logic [1:0] {
        MODE_RD     = 2'd0,
        MODE_WR     = 2'd1,
        MODE_RUN_RD = 2'd2,
        MODE_RUN_WR = 2'd3
    } mode_t;

    typedef struct packed {
        logic go;
        logic may_alloc;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic alloc;
    } scan_res_t;

endpackage

`default_nettype wire

FILE: sv/sector_cache_fifo_tags.sv
// sector_cache_fifo_tags: tag and fifo replacement engine of a fully associative
// sector cache. when the cache is off, done follows in the cycle after accept;
// otherwise the scan reads one tag per cycle and done comes when the key is found
// in a filled slot or the scan runs past the last filled slot. busy is high while
// scanning; one word at a time, done cannot stall. reset clears the fill count
// and pointer at once, no clearing pass; cache_enable=1
`default_nettype none

module sector_cache_fifo_tags #(
    parameter int SLOTS     = sctag_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = sctag_pkg::ADDR_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    mode,
    input  wire logic [sctag_pkg::LBA_W-1:0]   lba,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_data,
    output logic                               done,
    output logic                               hit,
    output logic [sctag_pkg::SLOT_W-1:0]       slot,
    output logic                               store_data,
    output logic                               device_read,
    output logic                               device_write
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam int SX_W  = (PTR_W > sctag_pkg::SLOT_W) ? PTR_W : sctag_pkg::SLOT_W;

    logic                             enable_reg;
    logic                             is_write_reg;
    logic                             done_reg;
    logic                             hit_reg;
    logic [sctag_pkg::SLOT_W-1:0]     slot_reg;
    logic                             store_reg;
    logic                             dev_rd_reg;
    logic                             dev_wr_reg;

    logic                             accept;
    logic                             is_write;
    logic                             eng_busy;
    sctag_pkg::scan_req_t             eng_req;
    sctag_pkg::scan_res_t             eng_res;
    logic [PTR_W-1:0]                 eng_slot;
    logic [sctag_pkg::KEY_EXT_W-1:0]  lba_ext;
    logic [ADDR_BITS-1:0]             key;
    logic [SX_W-1:0]                  slot_ext;

    assign accept   = start && !eng_busy;
    assign is_write = mode inside {sctag_pkg::MODE_WR, sctag_pkg::MODE_RUN_WR};
    assign lba_ext  = sctag_pkg::KEY_EXT_W'(lba);
    assign key      = lba_ext[ADDR_BITS-1:0];
    assign slot_ext = SX_W'(eng_slot);

    always_comb
    begin
        eng_req.go        = accept && enable_reg;
        eng_req.may_alloc = mode inside {sctag_pkg::MODE_RD, sctag_pkg::MODE_WR};
    end

    sctag_engine #(
        .SLOTS     (SLOTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (eng_req),
        .key      (key),
        .busy     (eng_busy),
        .res      (eng_res),
        .slot_idx (eng_slot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_data;
            end
            done_reg <= (accept && !enable_reg) || eng_res.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_write_reg <= is_write;
        end
        if (accept && !enable_reg)
        begin
            // cache off, straight to the device
            hit_reg    <= 1'b0;
            slot_reg   <= '0;
            store_reg  <= 1'b0;
            dev_rd_reg <= !is_write;
            dev_wr_reg <= is_write;
        end
        else if (eng_res.done)
        begin
            hit_reg    <= eng_res.hit;
            slot_reg   <= (eng_res.hit || eng_res.alloc) ? slot_ext[sctag_pkg::SLOT_W-1:0]
                                                         : '0;
            store_reg  <= eng_res.hit ? is_write_reg : eng_res.alloc;
            dev_rd_reg <= !is_write_reg && !eng_res.hit;
            dev_wr_reg <= is_write_reg;
        end
    end

    assign busy         = eng_busy;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign store_data   = store_reg;
    assign device_read  = dev_rd_reg;
    assign device_write = dev_wr_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(device_read && device_write))
        else $error("device read and write in one word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !device_read)
        else $error("device read on a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !enable_reg) |=> done && !hit && !store_data)
        else $error("disabled access did not bypass the cache");

endmodule

`default_nettype wire

FILE: sv/sctag_engine.sv
// sctag_engine: tag memory, fifo eviction pointer and fill count, and the
// sequential tag scan; depends on sctag_pkg
`default_nettype none

module sctag_engine #(
    parameter int SLOTS     = sctag_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = sctag_pkg::ADDR_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sctag_pkg::scan_req_t      req,
    input  wire logic [ADDR_BITS-1:0]      key,
    output logic                           busy,
    output sctag_pkg::scan_res_t           res,
    output logic [$clog2(SLOTS)-1:0]       slot_idx
);

    localparam int PTR_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } scan_state_t;

    scan_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic                 pend_reg, pend_next;
    logic [PTR_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [ADDR_BITS-1:0] key_reg, key_next;
    logic                 alloc_ok_reg, alloc_ok_next;

    logic [ADDR_BITS-1:0] tag_mem [SLOTS];
    logic [ADDR_BITS-1:0] rdata_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic                 match;
    logic                 miss;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        key_next      = key_reg;
        alloc_ok_next = alloc_ok_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        match         = 1'b0;
        miss          = 1'b0;
        res           = '0;
        slot_idx      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.go)
                begin
                    state_next    = ST_SCAN;
                    idx_next      = '0;
                    key_next      = key;
                    alloc_ok_next = req.may_alloc;
                end
            end
            ST_SCAN:
            begin
                match = pend_reg && (rdata_reg == key_reg);
                miss  = !pend_reg && (idx_reg >= fill_reg);
                if (match)
                begin
                    state_next = ST_IDLE;
                    res.done   = 1'b1;
                    res.hit    = 1'b1;
                    slot_idx   = pend_idx_reg;
                end
                else if (miss)
                begin
                    state_next = ST_IDLE;
                    res.done   = 1'b1;
                    if (alloc_ok_reg)
                    begin
                        res.alloc = 1'b1;
                        slot_idx  = ptr_reg;
                        wr_en     = 1'b1;
                        ptr_next  = (ptr_reg == PTR_W'(SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
                        fill_next = (fill_reg == CNT_W'(SLOTS)) ? fill_reg
                                                                : fill_reg + 1'b1;
                    end
                end
                else if (idx_reg < fill_reg)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[PTR_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        alloc_ok_reg <= alloc_ok_next;
    end

    // tag memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[ptr_reg] <= key_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= tag_mem[idx_reg[PTR_W-1:0]];
        end
    end

    // slots below the fill count are the valid ones
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(SLOTS))
        else $error("fill count beyond slot count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != CNT_W'(SLOTS)) |-> (CNT_W'(ptr_reg) == fill_reg))
        else $error("eviction pointer out of step with fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.done && res.hit) |-> (CNT_W'(pend_idx_reg) < fill_reg))
        else $error("hit reported on a slot that was never filled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("tag read pending while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.done |=> (state_reg == ST_IDLE) && !pend_reg)
        else $error("scan kept running after finishing");

endmodule

`default_nettype wire

FILE: tb/sv/sector_cache_fifo_tags_tb.sv
// sector_cache_fifo_tags_tb: self-checking bench for the sector cache tag engine,
// a directed table followed by random accesses in phases with the cache on and off
// depends on sctag_pkg and sector_cache_fifo_tags
module sector_cache_fifo_tags_tb;

    typedef sctag_pkg::mode_t mode_t;

    localparam int LBA_W        = sctag_pkg::LBA_W;
    localparam int SLOT_W       = sctag_pkg::SLOT_W;
    localparam int NSLOT        = sctag_pkg::SLOTS_DEF;
    localparam int CLK_HALF     = 4;
    localparam int SCAN_MAX     = NSLOT + 3;
    localparam int POOL_DEPTH   = 200;
    localparam int PHASES       = 7;
    localparam int MAX_PRINTS   = 50;
    localparam longint LIMIT_CYCLES = 2_500_000;

    localparam logic [LBA_W-1:0] LBA_ONES = '1;
    localparam logic [LBA_W-1:0] LBA_ALT5 = 48'h5555_5555_5555;
    localparam logic [LBA_W-1:0] LBA_ALTA = 48'hAAAA_AAAA_AAAA;
    localparam logic [LBA_W-1:0] LBA_TOP  = 48'h8000_0000_0000;
    localparam logic [LBA_W-1:0] LBA_MIX  = 48'h1234_5678_9ABC;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              store_data;
        logic              device_read;
        logic              device_write;
    } sector_res_t;

    typedef struct {
        bit               cfg_row;
        logic             cfg_val;
        mode_t            mode;
        logic [LBA_W-1:0] lba;
        bit               literal;
        sector_res_t      res;
    } dir_row_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    mode_t             mode     = sctag_pkg::MODE_RD;
    logic [LBA_W-1:0]  lba      = '0;
    logic              cfg_we   = 1'b0;
    logic              cfg_data = 1'b0;
    logic              busy;
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              store_data;
    logic              device_read;
    logic              device_write;

    // predictor state
    logic [LBA_W-1:0] tag_copy [NSLOT];
    bit               valid_copy [NSLOT];
    int unsigned      fill_ptr    = 0;
    bit               enable_copy = 1'b1;

    sector_res_t      pending_q [$];
    dir_row_t         dir_q [$];
    logic [LBA_W-1:0] addr_pool [POOL_DEPTH];

    int errors     = 0;
    int accepted   = 0;
    int checked    = 0;
    int hits_seen  = 0;
    int allocs     = 0;
    int cfg_writes = 0;

    sector_cache_fifo_tags dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .lba          (lba),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .hit          (hit),
        .slot         (slot),
        .store_data   (store_data),
        .device_read  (device_read),
        .device_write (device_write)
    );

    always #CLK_HALF clk = ~clk;

    function automatic sector_res_t predict_access(mode_t m, logic [LBA_W-1:0] a);
        sector_res_t r;
        bit          is_wr;
        bit          is_run;
        bit          found;
        int          where;
        r      = '0;
        is_wr  = m inside {sctag_pkg::MODE_WR, sctag_pkg::MODE_RUN_WR};
        is_run = m inside {sctag_pkg::MODE_RUN_RD, sctag_pkg::MODE_RUN_WR};
        found  = 1'b0;
        where  = 0;
        if (!enable_copy)
        begin
            r.device_write = is_wr;
            r.device_read  = !is_wr;
            return r;
        end
        // lowest matching slot wins
        for (int i = 0; i < NSLOT && !found; i++)
        begin
            if (valid_copy[i] && tag_copy[i] == a)
            begin
                found = 1'b1;
                where = i;
            end
        end
        if (found)
        begin
            r.hit          = 1'b1;
            r.slot         = SLOT_W'(where);
            r.store_data   = is_wr;
            r.device_write = is_wr;
            hits_seen++;
        end
        else
        begin
            r.device_write = is_wr;
            r.device_read  = !is_wr;
            if (!is_run)
            begin
                r.slot               = SLOT_W'(fill_ptr);
                r.store_data         = 1'b1;
                tag_copy[fill_ptr]   = a;
                valid_copy[fill_ptr] = 1'b1;
                fill_ptr             = (fill_ptr + 1) % NSLOT;
                allocs++;
            end
        end
        return r;
    endfunction

    function automatic logic [LBA_W-1:0] fresh_lba();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = '1;
            1: w = '0;
            2: w = 64'd1 << $urandom_range(0, LBA_W - 1);
            3: w = ~(64'd1 << $urandom_range(0, LBA_W - 1));
            default: ;
        endcase
        return w[LBA_W-1:0];
    endfunction

    // mostly reuse earlier addresses so hits land in slots all over the store
    function automatic logic [LBA_W-1:0] pick_lba();
        logic [LBA_W-1:0] a;
        if ($urandom_range(0, 99) < 55)
            return addr_pool[$urandom_range(0, POOL_DEPTH - 1)];
        a = fresh_lba();
        addr_pool[$urandom_range(0, POOL_DEPTH - 1)] = a;
        return a;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (errors < MAX_PRINTS)
            $display("mismatch at %0t, result %0d: %s got %0h expected %0h",
                     $realtime, checked, what, got, want);
        errors++;
    endtask

    task automatic add_access(mode_t m, logic [LBA_W-1:0] a, bit literal, sector_res_t r);
        dir_row_t row;
        row.cfg_row = 1'b0;
        row.cfg_val = 1'b0;
        row.mode    = m;
        row.lba     = a;
        row.literal = literal;
        row.res     = r;
        dir_q.push_back(row);
    endtask

    task automatic add_cfg(logic v);
        dir_row_t row;
        row.cfg_row = 1'b1;
        row.cfg_val = v;
        row.mode    = sctag_pkg::MODE_RD;
        row.lba     = '0;
        row.literal = 1'b0;
        row.res     = '0;
        dir_q.push_back(row);
    endtask

    task automatic send_access(mode_t m, logic [LBA_W-1:0] a, bit literal,
                               sector_res_t lit_res);
        sector_res_t r;
        start <= 1'b1;
        mode  <= m;
        lba   <= a;
        do
            @(posedge clk);
        while (busy);
        r = predict_access(m, a);
        pending_q.push_back(literal ? lit_res : r);
        accepted++;
    endtask

    task automatic drain(int extra);
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_enable(logic v);
        drain(4);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        enable_copy  = v;
        cfg_writes++;
    endtask

    task automatic maybe_gap(bit allow);
        if (allow && $urandom_range(0, 99) < 35)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        sector_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_q.size() == 0)
                report_mismatch("word with nothing expected", 0, 0);
            else
            begin
                want = pending_q.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (slot !== want.slot)
                    report_mismatch("slot", slot, want.slot);
                if (store_data !== want.store_data)
                    report_mismatch("store_data", store_data, want.store_data);
                if (device_read !== want.device_read)
                    report_mismatch("device_read", device_read, want.device_read);
                if (device_write !== want.device_write)
                    report_mismatch("device_write", device_write, want.device_write);
                checked++;
            end
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int               n_items;
        logic             en_now;
        bit               gaps_on;
        mode_t            m;
        logic [LBA_W-1:0] a;

        for (int i = 0; i < POOL_DEPTH; i++)
            addr_pool[i] = fresh_lba();

        // hit, slot, store_data, device_read, device_write
        add_access(sctag_pkg::MODE_RD,     '0,       1, {1'b0, 8'd0, 1'b1, 1'b1, 1'b0});
        add_access(sctag_pkg::MODE_RD,     '0,       1, {1'b1, 8'd0, 1'b0, 1'b0, 1'b0});
        add_access(sctag_pkg::MODE_WR,     LBA_ONES, 1, {1'b0, 8'd1, 1'b1, 1'b0, 1'b1});
        add_access(sctag_pkg::MODE_WR,     LBA_ONES, 1, {1'b1, 8'd1, 1'b1, 1'b0, 1'b1});
        add_access(sctag_pkg::MODE_RUN_RD, LBA_ALT5, 1, {1'b0, 8'd0, 1'b0, 1'b1, 1'b0});
        add_access(sctag_pkg::MODE_RUN_WR, LBA_ALTA, 1, {1'b0, 8'd0, 1'b0, 1'b0, 1'b1});
        add_access(sctag_pkg::MODE_RUN_RD, LBA_ONES, 1, {1'b1, 8'd1, 1'b0, 1'b0, 1'b0});
        add_access(sctag_pkg::MODE_RUN_WR, '0,       1, {1'b1, 8'd0, 1'b1, 1'b0, 1'b1});
        add_access(sctag_pkg::MODE_RD,     LBA_ALT5, 0, '0);
        add_access(sctag_pkg::MODE_RD,     LBA_ALTA, 0, '0);
        add_access(sctag_pkg::MODE_RUN_RD, LBA_ALTA, 0, '0);
        add_access(sctag_pkg::MODE_WR,     48'd1,    0, '0);
        add_access(sctag_pkg::MODE_RD,     LBA_TOP,  0, '0);
        add_access(sctag_pkg::MODE_RUN_WR, LBA_TOP,  0, '0);
        // cache off: straight to the device, state untouched
        add_cfg(1'b0);
        add_access(sctag_pkg::MODE_RD,     '0,       1, {1'b0, 8'd0, 1'b0, 1'b1, 1'b0});
        add_access(sctag_pkg::MODE_WR,     LBA_ONES, 1, {1'b0, 8'd0, 1'b0, 1'b0, 1'b1});
        add_access(sctag_pkg::MODE_RUN_RD, LBA_ALT5, 1, {1'b0, 8'd0, 1'b0, 1'b1, 1'b0});
        add_access(sctag_pkg::MODE_RUN_WR, 48'd1,    1, {1'b0, 8'd0, 1'b0, 1'b0, 1'b1});
        add_cfg(1'b1);
        add_access(sctag_pkg::MODE_RD,     '0,       0, '0);
        add_access(sctag_pkg::MODE_RD,     LBA_MIX,  0, '0);
        add_access(sctag_pkg::MODE_RUN_WR, LBA_MIX,  0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_q[i])
        begin
            if (dir_q[i].cfg_row)
                write_enable(dir_q[i].cfg_val);
            else
            begin
                send_access(dir_q[i].mode, dir_q[i].lba, dir_q[i].literal, dir_q[i].res);
                maybe_gap(1'b1);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            en_now  = (p == 1 || p == 4) ? 1'b0 : 1'b1;
            n_items = en_now ? 300 : 100;
            gaps_on = (p != 2);
            write_enable(en_now);
            for (int k = 0; k < n_items; k++)
            begin
                m = mode_t'($urandom_range(0, 3));
                a = pick_lba();
                send_access(m, a, 1'b0, '0);
                if (p == 3 && k == n_items / 2)
                    drain(1);
                else
                    maybe_gap(gaps_on);
            end
        end

        drain(SCAN_MAX);
        $display("covered %0d accesses in %0d enable settings: %0d hits, %0d allocations",
                 accepted, cfg_writes, hits_seen, allocs);
        $display("eviction pointer went round %0d times, %0d result words checked",
                 allocs / NSLOT, checked);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/sctag_pkg.sv
sv/sctag_engine.sv
sv/sector_cache_fifo_tags.sv
tb/sv/sector_cache_fifo_tags_tb.sv
